### rtl/refcounted_block_pool_allocator_assert.svh
// ----------------------------------------------------------------------------
// refcounted_block_pool_allocator assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define REFCOUNTED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
// condition holds at every clock edge out of reset
`define RBPA_ASSERT_HOLD(lbl, clk_i, rst_i, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (cond)) \
    else $error("rbpa: invariant violated");
// consequence holds in the cycle after the antecedent
`define RBPA_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("rbpa: sequence violated");
`else
`define RBPA_ASSERT_HOLD(lbl, clk_i, rst_i, cond)
`define RBPA_ASSERT_NEXT(lbl, clk_i, rst_i, ante, cons)
`endif

`endif

### rtl/rbpa_pkg.sv
// ----------------------------------------------------------------------------
// rbpa_pkg
// Shared widths, codes and defaults of the block pool allocator
// ----------------------------------------------------------------------------
package rbpa_pkg;

  // payload field widths
  localparam int FUNC_W     = 2;
  localparam int IDX_PORT_W = 8;
  localparam int STATUS_W   = 3;
  localparam int OFF_W      = 20;
  localparam int REF_PORT_W = 8;

  // configuration port
  localparam int POOL_CFG_W = 9;
  localparam int BB_CFG_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BLOCKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b1;

  localparam logic [POOL_CFG_W-1:0] POOL_BLOCKS_RESET = 9'd256;
  localparam logic [BB_CFG_W-1:0]   BLOCK_BYTES_RESET = 13'd64;
  localparam logic [BB_CFG_W-1:0]   MAX_BLOCK_BYTES   = 13'd4096;

  // defaults of the top level parameters
  localparam int DEF_NUM_BLOCKS = 256;
  localparam int DEF_REF_BITS   = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC   = 2'd0,
    FN_ADD_REF = 2'd1,
    FN_FREE    = 2'd2,
    FN_INVALID = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [IDX_PORT_W-1:0] granted_index;
    logic [OFF_W-1:0]      byte_offset;
    logic [REF_PORT_W-1:0] ref_after;
  } rsp_t;

endpackage

### rtl/rbpa_if.sv
// ----------------------------------------------------------------------------
// rbpa_if
// Request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface rbpa_req_if;
  logic                                valid;
  logic                                ready;
  logic [rbpa_pkg::FUNC_W-1:0]         func;
  logic [rbpa_pkg::IDX_PORT_W-1:0]     handle_index;

  modport source(output valid, func, handle_index, input ready);
  modport sink(input valid, func, handle_index, output ready);
endinterface

interface rbpa_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [rbpa_pkg::STATUS_W-1:0]       status;
  logic [rbpa_pkg::IDX_PORT_W-1:0]     granted_index;
  logic [rbpa_pkg::OFF_W-1:0]          byte_offset;
  logic [rbpa_pkg::REF_PORT_W-1:0]     ref_after;

  modport source(output valid, status, granted_index, byte_offset, ref_after, input ready);
  modport sink(input valid, status, granted_index, byte_offset, ref_after, output ready);
endinterface

### rtl/rbpa_ram.sv
// ----------------------------------------------------------------------------
// rbpa_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module rbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/refcounted_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// refcounted_block_pool_allocator
// Fixed-size block pool with a LIFO recycled list and per-block ref counts
// ----------------------------------------------------------------------------
//
//   channel  dir  fields                                         handshake
//   -------  ---  ---------------------------------------------  -----------
//   req      in   func, handle_index                             valid/ready
//   rsp      out  status, granted_index, byte_offset, ref_after  valid/ready
//   cfg      in   cfg_index, cfg_wdata                           cfg_we only
//
// one request per cycle sustained while rsp.ready keeps the queue drained; a result
// enters the queue at the edge after its transaction and is valid from then on,
// that cycle being spent on the registered read of the ref count ram
// reset is synchronous and instant: ref counts at or above the fresh count read
// as zero, so the count ram needs no clearing pass
// results wait in a three-entry queue; req.ready drops only when that queue
// plus the request in flight would fill it
//
`include "refcounted_block_pool_allocator_assert.svh"

module refcounted_block_pool_allocator #(
  parameter int NUM_BLOCKS = rbpa_pkg::DEF_NUM_BLOCKS,
  parameter int REF_BITS   = rbpa_pkg::DEF_REF_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  rbpa_req_if.sink                           req,
  rbpa_rsp_if.source                         rsp,
  input  logic                               cfg_we,
  input  logic [rbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbpa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int IDX_W   = $clog2(NUM_BLOCKS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int CMP_W   = (CNT_W > rbpa_pkg::IDX_PORT_W) ? CNT_W : rbpa_pkg::IDX_PORT_W;
  localparam int PROD_W  = IDX_W + rbpa_pkg::BB_CFG_W;
  localparam int Q_DEPTH = 3;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [CNT_W-1:0]    LIST_EMPTY = CNT_W'(NUM_BLOCKS);
  localparam logic [REF_BITS-1:0] REF_MAX    = {REF_BITS{1'b1}};

  // configuration registers
  logic [rbpa_pkg::POOL_CFG_W-1:0] pool_blocks;
  logic [rbpa_pkg::BB_CFG_W-1:0]   block_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_blocks <= rbpa_pkg::POOL_BLOCKS_RESET;
      block_bytes <= rbpa_pkg::BLOCK_BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rbpa_pkg::CFG_POOL_BLOCKS: pool_blocks <= rbpa_pkg::POOL_CFG_W'(cfg_wdata);
        rbpa_pkg::CFG_BLOCK_BYTES: block_bytes <= rbpa_pkg::BB_CFG_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // effective pool size and block size
  logic [CNT_W-1:0]              pool_eff;
  logic [rbpa_pkg::BB_CFG_W-1:0] bb_eff;

  assign pool_eff = (32'(pool_blocks) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                     : CNT_W'(pool_blocks);
  assign bb_eff   = (block_bytes > rbpa_pkg::MAX_BLOCK_BYTES) ? rbpa_pkg::MAX_BLOCK_BYTES
                                                               : block_bytes;

  // request stage register, filled on every transaction
  logic                            v1;
  logic [rbpa_pkg::FUNC_W-1:0]     f1;
  logic [rbpa_pkg::IDX_PORT_W-1:0] h1;
  logic                            req_acc;

  assign req_acc = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= req_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      f1 <= req.func;
      h1 <= req.handle_index;
    end
  end

  // allocator state
  logic [CNT_W-1:0] free_head;
  logic [CNT_W-1:0] free_head_next;
  logic [CNT_W-1:0] fresh_count;
  logic [CNT_W-1:0] fresh_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head   <= LIST_EMPTY;
      fresh_count <= '0;
    end else begin
      free_head   <= free_head_next;
      fresh_count <= fresh_count_next;
    end
  end

  // ref count ram, read at the request index as the transaction is taken
  logic                rc_we;
  logic [IDX_W-1:0]    rc_waddr;
  logic [REF_BITS-1:0] rc_wdata;
  logic [IDX_W-1:0]    rc_raddr;
  logic [REF_BITS-1:0] rc_rdata;
  logic                rc_byp;
  logic [REF_BITS-1:0] rc_byp_data;
  logic [REF_BITS-1:0] rc_cur;

  assign rc_raddr = IDX_W'(req.handle_index);

  rbpa_ram #(
    .WIDTH (REF_BITS),
    .DEPTH (NUM_BLOCKS)
  ) u_rc_ram (
    .clk   (clk),
    .we    (rc_we),
    .waddr (rc_waddr),
    .wdata (rc_wdata),
    .raddr (rc_raddr),
    .rdata (rc_rdata)
  );

  // link ram, always read at the head the list will have next cycle
  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  logic [IDX_W-1:0] link_wdata;
  logic [IDX_W-1:0] link_raddr;
  logic [IDX_W-1:0] link_rdata;
  logic             link_byp;
  logic [IDX_W-1:0] link_byp_data;
  logic [IDX_W-1:0] link_cur;

  assign link_raddr = free_head_next[IDX_W-1:0];

  rbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // write-to-read forwarding: a write and a read of one entry at the same
  // edge hand the written value to the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rc_byp   <= 1'b0;
      link_byp <= 1'b0;
    end else begin
      rc_byp   <= rc_we && (rc_waddr == rc_raddr);
      link_byp <= link_we && (link_waddr == link_raddr);
    end
  end

  always_ff @(posedge clk) begin
    rc_byp_data   <= rc_wdata;
    link_byp_data <= link_wdata;
  end

  assign rc_cur   = rc_byp ? rc_byp_data : rc_rdata;
  assign link_cur = link_byp ? link_byp_data : link_rdata;

  // request evaluation
  logic [REF_BITS-1:0]               cnt;
  logic [REF_BITS-1:0]               cnt_dec;
  logic                              in_pool;
  logic [rbpa_pkg::STATUS_W-1:0]     res_status;
  logic [rbpa_pkg::IDX_PORT_W-1:0]   res_gidx;
  logic                              res_off_en;
  logic [IDX_W-1:0]                  off_idx;
  logic [REF_BITS-1:0]               res_ref;
  logic [PROD_W-1:0]                 prod;
  rbpa_pkg::rsp_t                    res;

  // entries at or above the fresh count were never handed out: count zero
  assign cnt     = (CMP_W'(h1) < CMP_W'(fresh_count)) ? rc_cur : '0;
  assign cnt_dec = cnt - REF_BITS'(1);
  assign in_pool = CMP_W'(h1) < CMP_W'(pool_eff);

  always_comb begin
    res_status       = rbpa_pkg::ST_OK;
    res_gidx         = '0;
    res_off_en       = 1'b0;
    off_idx          = IDX_W'(h1);
    res_ref          = '0;
    rc_we            = 1'b0;
    rc_waddr         = IDX_W'(h1);
    rc_wdata         = '0;
    link_we          = 1'b0;
    link_waddr       = IDX_W'(h1);
    link_wdata       = '0;
    free_head_next   = free_head;
    fresh_count_next = fresh_count;
    if (v1 && !rst) begin
      unique case (rbpa_pkg::func_t'(f1))
        rbpa_pkg::FN_ALLOC: begin
          if (free_head != LIST_EMPTY) begin
            // pop the most recently recycled block; a self link ends the list
            off_idx        = free_head[IDX_W-1:0];
            free_head_next = (link_cur == free_head[IDX_W-1:0]) ? LIST_EMPTY
                                                                : CNT_W'(link_cur);
          end else if (fresh_count < pool_eff) begin
            off_idx          = fresh_count[IDX_W-1:0];
            fresh_count_next = fresh_count + CNT_W'(1);
          end else begin
            res_status = rbpa_pkg::ST_EXHAUSTED;
          end
          if (res_status == rbpa_pkg::ST_OK) begin
            res_gidx   = rbpa_pkg::IDX_PORT_W'(off_idx);
            res_off_en = 1'b1;
            res_ref    = REF_BITS'(1);
            rc_we      = 1'b1;
            rc_waddr   = off_idx;
            rc_wdata   = REF_BITS'(1);
          end
        end
        rbpa_pkg::FN_ADD_REF: begin
          res_gidx = h1;
          if (!in_pool || cnt == '0) begin
            res_status = rbpa_pkg::ST_BAD_INDEX;
          end else if (cnt == REF_MAX) begin
            res_status = rbpa_pkg::ST_OVERFLOW;
            res_off_en = 1'b1;
            res_ref    = cnt;
          end else begin
            res_off_en = 1'b1;
            res_ref    = cnt + REF_BITS'(1);
            rc_we      = 1'b1;
            rc_wdata   = cnt + REF_BITS'(1);
          end
        end
        rbpa_pkg::FN_FREE: begin
          res_gidx = h1;
          if (!in_pool) begin
            res_status = rbpa_pkg::ST_BAD_INDEX;
          end else if (cnt == '0) begin
            res_status = rbpa_pkg::ST_UNDERFLOW;
            res_off_en = 1'b1;
          end else begin
            res_off_en = 1'b1;
            res_ref    = cnt_dec;
            rc_we      = 1'b1;
            rc_wdata   = cnt_dec;
            if (cnt_dec == '0) begin
              // push; the first block on an empty list links to itself
              link_we        = 1'b1;
              link_wdata     = (free_head != LIST_EMPTY) ? free_head[IDX_W-1:0]
                                                         : IDX_W'(h1);
              free_head_next = CNT_W'(h1);
            end
          end
        end
        rbpa_pkg::FN_INVALID: begin
          res_status = rbpa_pkg::ST_BAD_INDEX;
        end
      endcase
    end
  end

  assign prod = PROD_W'(off_idx) * PROD_W'(bb_eff);

  assign res.status        = res_status;
  assign res.granted_index = res_gidx;
  assign res.byte_offset   = res_off_en ? rbpa_pkg::OFF_W'(prod) : '0;
  assign res.ref_after     = rbpa_pkg::REF_PORT_W'(res_ref);

  // result queue
  rbpa_pkg::rsp_t      q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  q_count;
  logic                q_push;
  logic                q_pop;
  rbpa_pkg::rsp_t      q_head;

  assign q_push = v1;
  assign q_pop  = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      q_count <= q_count + Q_CNT_W'(q_push) - Q_CNT_W'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[wr_ptr] <= res;
    end
  end

  // room for the request in flight and one more, without counting on a pop
  assign req.ready = ((Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(v1))
                     <= (Q_CNT_W + 1)'(Q_DEPTH - 1);

  assign q_head            = q_mem[rd_ptr];
  assign rsp.valid         = (q_count != '0);
  assign rsp.status        = q_head.status;
  assign rsp.granted_index = q_head.granted_index;
  assign rsp.byte_offset   = q_head.byte_offset;
  assign rsp.ref_after     = q_head.ref_after;

  // fresh blocks are never handed out past the built depth
  `RBPA_ASSERT_HOLD(a_fresh_bound, clk, rst, fresh_count <= CNT_W'(NUM_BLOCKS))
  // the recycled list only ever holds blocks that were handed out before
  `RBPA_ASSERT_HOLD(a_head_issued, clk, rst, (free_head == LIST_EMPTY) || (free_head < fresh_count))
  // a request in evaluation always lands in the result queue
  `RBPA_ASSERT_NEXT(a_result_lands, clk, rst, v1, q_count != '0)

endmodule

### test/tb_refcounted_block_pool_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_refcounted_block_pool_allocator
// Self-checking bench: a walked table of directed requests, then randomized
// request mixes under several pool and block sizes, with both handshake sides
// idling and stalling at random; every response is compared with a scoreboard
// fed by an in-bench model of the pool
// ----------------------------------------------------------------------------
module tb_refcounted_block_pool_allocator;
  import rbpa_pkg::*;

  localparam int          NBLK    = DEF_NUM_BLOCKS;
  localparam int unsigned REF_TOP = (1 << DEF_REF_BITS) - 1;
  localparam int          GAP_MAX = 13;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_POOL_BLOCKS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  rbpa_req_if req ();
  rbpa_rsp_if rsp ();

  refcounted_block_pool_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // pool model: own copy of counts, recycled list and registers
  // --------------------------------------------------------------------------
  logic [7:0]            m_refs [NBLK];
  logic [7:0]            m_link [NBLK];
  logic [8:0]            m_head  = 9'(NBLK);       // NBLK marks an empty list
  logic [8:0]            m_fresh = '0;
  logic [POOL_CFG_W-1:0] m_pool  = POOL_BLOCKS_RESET;
  logic [BB_CFG_W-1:0]   m_bytes = BLOCK_BYTES_RESET;

  rsp_t        pending_grants [$];   // responses still owed by the dut
  int unsigned errors  = 0;
  int unsigned sent_n  = 0;
  int unsigned got_n   = 0;
  int unsigned status_seen [5];
  bit          offering  = 1'b0;     // req.valid currently driven high
  bit          cfg_busy  = 1'b0;     // cfg_we currently driven high
  bit          tx_burst  = 1'b0;

  initial begin
    for (int i = 0; i < NBLK; i++) begin
      m_refs[i] = '0;
      m_link[i] = '0;
    end
    for (int i = 0; i < 5; i++) status_seen[i] = 0;
  end

  function automatic rsp_t grant_word(status_t st, logic [7:0] idx, bit with_off,
                                      logic [7:0] refs);
    int unsigned bb;
    rsp_t        r;
    bb = (m_bytes > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : m_bytes;
    r.status        = st;
    r.granted_index = idx;
    r.byte_offset   = with_off ? 20'(idx * bb) : '0;
    r.ref_after     = refs;
    return r;
  endfunction

  // effect of one request on the model, and the response it earns
  function automatic rsp_t grant_outcome(func_t f, logic [7:0] h);
    int unsigned pe;
    int unsigned b;
    logic [7:0]  c;
    pe = (m_pool > NBLK) ? NBLK : m_pool;
    case (f)
      FN_ALLOC: begin
        if (m_head < NBLK) begin
          // pop; a self link is the list end
          b = m_head;
          m_head = (m_link[b] == b) ? 9'(NBLK) : 9'(m_link[b]);
        end else if (m_fresh < pe) begin
          b = m_fresh;
          m_fresh = m_fresh + 1'b1;
        end else begin
          return grant_word(ST_EXHAUSTED, '0, 1'b0, '0);
        end
        m_refs[b] = 8'd1;
        return grant_word(ST_OK, 8'(b), 1'b1, 8'd1);
      end
      FN_INVALID: return grant_word(ST_BAD_INDEX, '0, 1'b0, '0);
      default: begin
        if (h >= pe) return grant_word(ST_BAD_INDEX, h, 1'b0, '0);
        c = m_refs[h];
        if (f == FN_ADD_REF) begin
          if (c == 0) return grant_word(ST_BAD_INDEX, h, 1'b0, '0);
          if (c >= REF_TOP) return grant_word(ST_OVERFLOW, h, 1'b1, c);
          m_refs[h] = c + 1'b1;
          return grant_word(ST_OK, h, 1'b1, c + 1'b1);
        end
        // free: a count reaching zero pushes the block onto the recycled list
        if (c == 0) return grant_word(ST_UNDERFLOW, h, 1'b1, '0);
        c = c - 1'b1;
        m_refs[h] = c;
        if (c == 0) begin
          m_link[h] = (m_head < NBLK) ? 8'(m_head) : h;
          m_head    = 9'(h);
        end
        return grant_word(ST_OK, h, 1'b1, c);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // mismatch reporting and response checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    $display("mismatch at %0t: %s, expected %0d got %0d", $realtime, what, want, got);
    errors++;
  endtask

  task automatic check_grant();
    rsp_t want;
    if (pending_grants.size() == 0) begin
      flag_mismatch("response with nothing pending, index", 0, rsp.granted_index);
    end else begin
      want = pending_grants.pop_front();
      if (rsp.status !== want.status)
        flag_mismatch("status", want.status, rsp.status);
      if (rsp.granted_index !== want.granted_index)
        flag_mismatch("granted_index", want.granted_index, rsp.granted_index);
      if (rsp.byte_offset !== want.byte_offset)
        flag_mismatch("byte_offset", want.byte_offset, rsp.byte_offset);
      if (rsp.ref_after !== want.ref_after)
        flag_mismatch("ref_after", want.ref_after, rsp.ref_after);
    end
    got_n++;
  endtask

  // --------------------------------------------------------------------------
  // request side helpers
  // --------------------------------------------------------------------------
  task automatic end_writes();
    if (cfg_busy) cfg_we <= 1'b0;
    cfg_busy = 1'b0;
  endtask

  // drop valid and wait until every owed response has come back
  task automatic settle_pool();
    if (offering) req.valid <= 1'b0;
    offering = 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // registers change only with the pool idle; back-to-back writes keep cfg_we up
  task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] data);
    if (!cfg_busy) settle_pool();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    if (sel == CFG_POOL_BLOCKS) m_pool = data[POOL_CFG_W-1:0];
    else m_bytes = data[BB_CFG_W-1:0];
    @(posedge clk);
    cfg_busy = 1'b1;
  endtask

  // one request transaction; the expectation is queued at the accepting edge
  task automatic offer_request(func_t f, logic [7:0] h, bit typed, rsp_t typed_rsp);
    int unsigned gap;
    rsp_t        predicted;
    end_writes();
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    if (gap != 0) begin
      if (offering) req.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.func         <= f;
    req.handle_index <= h;
    offering = 1'b1;
    do @(posedge clk); while (req.ready !== 1'b1);
    predicted = grant_outcome(f, h);
    if (typed) predicted = typed_rsp;
    pending_grants.push_back(predicted);
    if (predicted.status < 5) status_seen[predicted.status]++;
    sent_n++;
  endtask

  // handle mostly among blocks handed out so far, sometimes at the pool edge
  function automatic logic [7:0] pick_handle();
    int unsigned r;
    int unsigned pe;
    r  = $urandom_range(0, 99);
    pe = (m_pool > NBLK) ? NBLK : m_pool;
    if (r < 70 && m_fresh > 0) return 8'($urandom_range(0, m_fresh - 1));
    if (r < 80 && pe > 0) return 8'($urandom_range(pe - 1, (pe > 255) ? 255 : pe));
    return 8'($urandom_range(0, 255));
  endfunction

  // random request mix; hot aims adds and frees at block 0 to drive its count up
  task automatic run_mix(int unsigned n, bit hot, int unsigned w_alloc,
                         int unsigned w_add, int unsigned w_free);
    int unsigned r;
    logic [7:0]  h;
    func_t       f;
    for (int unsigned k = 0; k < n; k++) begin
      // sender pause: let every response drain once mid-run
      if (sent_n == 600) settle_pool();
      r = $urandom_range(0, 99);
      h = (hot && $urandom_range(0, 7) != 0) ? 8'd0 : pick_handle();
      if (hot && m_refs[0] == 0) f = FN_ALLOC;
      else if (r < w_alloc) f = FN_ALLOC;
      else if (r < w_alloc + w_add) f = FN_ADD_REF;
      else if (r < w_alloc + w_add + w_free) f = FN_FREE;
      else begin
        f = FN_INVALID;
        h = 8'($urandom_range(0, 255));
      end
      offer_request(f, h, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // directed table: typed responses only where obvious, rest from the model
  // --------------------------------------------------------------------------
  typedef struct {
    bit                   cfg;
    logic [CFG_IDX_W-1:0] sel;
    logic [CFG_DATA_W-1:0] wdata;
    func_t                f;
    logic [7:0]           h;
    bit                   typed;
    rsp_t                 want;
  } step_row_t;

  step_row_t script [28] = '{
    // fresh blocks come out in ascending order after reset
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_ALLOC,   8'd0,   1'b1, '{ST_OK, 8'd0, 20'd0, 8'd1}},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_ALLOC,   8'd0,   1'b1, '{ST_OK, 8'd1, 20'd64, 8'd1}},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_ADD_REF, 8'd1,   1'b1, '{ST_OK, 8'd1, 20'd64, 8'd2}},
    // add reference to an unreferenced block, free of an unreferenced block
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_ADD_REF, 8'd255, 1'b1,
      '{ST_BAD_INDEX, 8'd255, 20'd0, 8'd0}},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_FREE,    8'd200, 1'b1,
      '{ST_UNDERFLOW, 8'd200, 20'd12800, 8'd0}},
    // unknown request code
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_INVALID, 8'd255, 1'b1,
      '{ST_BAD_INDEX, 8'd0, 20'd0, 8'd0}},
    // block 1 onto an empty list links to itself, then block 0 on top
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_FREE,    8'd1,   1'b0, '0},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_FREE,    8'd1,   1'b0, '0},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_FREE,    8'd0,   1'b0, '0},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_ALLOC,   8'd0,   1'b0, '0},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_ALLOC,   8'd0,   1'b0, '0},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_ALLOC,   8'd0,   1'b0, '0},
    // oversized registers clamp to the largest pool and block
    '{1'b1, CFG_BLOCK_BYTES, 13'd8191, FN_ALLOC, 8'd0,  1'b0, '0},
    '{1'b1, CFG_POOL_BLOCKS, 13'd511,  FN_ALLOC, 8'd0,  1'b0, '0},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_ADD_REF, 8'd2,   1'b0, '0},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_FREE,    8'd255, 1'b1,
      '{ST_UNDERFLOW, 8'd255, 20'd1044480, 8'd0}},
    // empty pool, zero block size
    '{1'b1, CFG_BLOCK_BYTES, 13'd0, FN_ALLOC,   8'd0,   1'b0, '0},
    '{1'b1, CFG_POOL_BLOCKS, 13'd0, FN_ALLOC,   8'd0,   1'b0, '0},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_ALLOC,   8'd0,   1'b1,
      '{ST_EXHAUSTED, 8'd0, 20'd0, 8'd0}},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_FREE,    8'd0,   1'b1,
      '{ST_BAD_INDEX, 8'd0, 20'd0, 8'd0}},
    // shrunk pool: block 1 recycled, then handed out from beyond the pool
    '{1'b1, CFG_POOL_BLOCKS, 13'd2, FN_ALLOC,   8'd0,   1'b0, '0},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_FREE,    8'd1,   1'b0, '0},
    '{1'b1, CFG_POOL_BLOCKS, 13'd1, FN_ALLOC,   8'd0,   1'b0, '0},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_ALLOC,   8'd0,   1'b0, '0},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_ALLOC,   8'd0,   1'b1,
      '{ST_EXHAUSTED, 8'd0, 20'd0, 8'd0}},
    '{1'b1, CFG_BLOCK_BYTES, 13'd4096, FN_ALLOC, 8'd0,  1'b0, '0},
    '{1'b1, CFG_POOL_BLOCKS, 13'd256,  FN_ALLOC, 8'd0,  1'b0, '0},
    '{1'b0, CFG_POOL_BLOCKS, 13'd0, FN_FREE,    8'd2,   1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // request process: reset, directed table, random phases, wrap-up
  // --------------------------------------------------------------------------
  initial begin
    req.valid        <= 1'b0;
    req.func         <= FN_ALLOC;
    req.handle_index <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 28; i++) begin
      if (script[i].cfg) write_reg(script[i].sel, script[i].wdata);
      else offer_request(script[i].f, script[i].h, script[i].typed, script[i].want);
    end

    // single-block pool with block 0 still live: climb its count into overflow
    write_reg(CFG_POOL_BLOCKS, 13'd1);
    write_reg(CFG_BLOCK_BYTES, 13'($urandom_range(1, 4096)));
    run_mix(420, 1'b1, 3, 89, 5);

    // full pool, balanced churn of the recycled list
    write_reg(CFG_POOL_BLOCKS, 13'd256);
    write_reg(CFG_BLOCK_BYTES, 13'($urandom_range(0, 8191)));
    run_mix(350, 1'b0, 40, 20, 37);

    // tiny pool, frequent exhaustion
    write_reg(CFG_POOL_BLOCKS, 13'($urandom_range(2, 12)));
    write_reg(CFG_BLOCK_BYTES, 13'($urandom_range(0, 8191)));
    run_mix(300, 1'b0, 45, 12, 40);

    // any register value at all
    write_reg(CFG_POOL_BLOCKS, 13'($urandom_range(0, 511)));
    write_reg(CFG_BLOCK_BYTES, 13'($urandom_range(0, 8191)));
    run_mix(230, 1'b0, 38, 22, 37);

    // wrap-up: bounded drain, then a further wait for anything stray
    end_writes();
    if (offering) req.valid <= 1'b0;
    offering = 1'b0;
    for (int w = 0; w < 4000 && pending_grants.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_grants.size() != 0)
      flag_mismatch("responses never delivered", 0, pending_grants.size());

    $display("ran %0d requests through directed cases and four random pool setups",
             sent_n);
    $display("answers: %0d ok, %0d exhausted, %0d bad index, %0d underflow, %0d overflow",
             status_seen[ST_OK], status_seen[ST_EXHAUSTED], status_seen[ST_BAD_INDEX],
             status_seen[ST_UNDERFLOW], status_seen[ST_OVERFLOW]);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // response process: random ready gaps plus two long hold-offs that back the
  // pool up until it stalls its request side
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    bit          rx_burst;
    rx_burst = 1'b0;
    rsp.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (got_n == 150 || got_n == 900) begin
        gap = 250;
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      end
      if (gap != 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (rsp.valid !== 1'b1);
      check_grant();
    end
  end

  // watchdog, several times the slowest legal run
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
